// ===== hw/rtl/uvsph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsph_pkg
// Shared constants, register indexes, arctangent table and small helpers
// for the UV sphere vertex pipeline.
// ----------------------------------------------------------------------------
package uvsph_pkg;

    localparam int MAX_SEGMENTS_DEF     = 1024;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    localparam int CNT_W   = 11;
    localparam int RAD_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int PHASE_W = 24;
    localparam int CW      = 34;   // CORDIC datapath width (Q2.30 plus guard)
    localparam int ZW      = 25;

    localparam logic [IDX_W-1:0] REG_SECTOR_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_STACK_COUNT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS       = 2'd2;

    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_lookup(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0: v = 25'sd2097152;  1: v = 25'sd1238021;  2: v = 25'sd654136;
            3: v = 25'sd332050;   4: v = 25'sd166669;   5: v = 25'sd83416;
            6: v = 25'sd41718;    7: v = 25'sd20860;    8: v = 25'sd10430;
            9: v = 25'sd5215;     10: v = 25'sd2608;    11: v = 25'sd1304;
            12: v = 25'sd652;     13: v = 25'sd326;     14: v = 25'sd163;
            15: v = 25'sd81;      16: v = 25'sd41;      17: v = 25'sd20;
            18: v = 25'sd10;      19: v = 25'sd5;       20: v = 25'sd3;
            21: v = 25'sd1;       22: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/uvsph_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsph_divider
// Pipelined restoring divider, one quotient bit per stage, with a stall
// enable shared by the whole pipeline. Carries a side payload alongside.
// ----------------------------------------------------------------------------
module uvsph_divider #(
    parameter int NUM_W  = 35,
    parameter int DEN_W  = 11,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              adv,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [NUM_W-1:0]  q_reg   [NUM_W+1];
    logic [DEN_W:0]    r_reg   [NUM_W+1];
    logic [NUM_W-1:0]  n_reg   [NUM_W+1];
    logic [DEN_W-1:0]  d_reg   [NUM_W+1];
    logic [SIDE_W-1:0] s_reg   [NUM_W+1];

    always_comb begin
        q_reg[0] = '0;
        r_reg[0] = '0;
        n_reg[0] = num;
        d_reg[0] = den;
        s_reg[0] = side_in;
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W+1:0] trial;
        logic             fits;
        always_comb begin
            trial = {r_reg[k], n_reg[k][NUM_W-1-k]};
            fits  = trial >= {2'b00, d_reg[k]};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                r_reg[k+1] <= fits ? DEN_W'(trial - {2'b00, d_reg[k]}) + (DEN_W+1)'(0)
                                   : trial[DEN_W:0];
                q_reg[k+1] <= q_reg[k] | (NUM_W'(fits) << (NUM_W-1-k));
                n_reg[k+1] <= n_reg[k];
                d_reg[k+1] <= d_reg[k];
                s_reg[k+1] <= s_reg[k];
            end
        end
    end

    assign quo      = q_reg[NUM_W];
    assign side_out = s_reg[NUM_W];

endmodule

// ===== hw/rtl/uvsph_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvsph_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage, followed by
// the quadrant fold. Gives cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module uvsph_cordic #(
    parameter int ITER = uvsph_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                              aclk,
    input  logic                              adv,
    input  logic [uvsph_pkg::PHASE_W-1:0]     phase,
    output logic signed [uvsph_pkg::CW-1:0]   cos_out,
    output logic signed [uvsph_pkg::CW-1:0]   sin_out
);

    localparam int CW = uvsph_pkg::CW;
    localparam int ZW = uvsph_pkg::ZW;

    logic signed [CW-1:0] x_reg [ITER+1];
    logic signed [CW-1:0] y_reg [ITER+1];
    logic signed [ZW-1:0] z_reg [ITER+1];
    logic [1:0]           q_reg [ITER+1];
    logic [24:0]          ph_sum;

    always_comb begin
        ph_sum   = {1'b0, phase} + 25'd2097152;
        x_reg[0] = uvsph_pkg::CORDIC_GAIN_Q30;
        y_reg[0] = '0;
        z_reg[0] = ZW'($signed({3'b000, ph_sum[21:0]})) - 25'sd2097152;
        q_reg[0] = ph_sum[23:22];
    end

    for (genvar i = 0; i < ITER; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - uvsph_pkg::atan_lookup(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + uvsph_pkg::atan_lookup(i);
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // fold the quadrant back in
    always_ff @(posedge aclk) begin
        if (adv) begin
            case (q_reg[ITER])
                2'd0: begin cos_out <= x_reg[ITER];  sin_out <= y_reg[ITER];  end
                2'd1: begin cos_out <= -y_reg[ITER]; sin_out <= x_reg[ITER];  end
                2'd2: begin cos_out <= -x_reg[ITER]; sin_out <= -y_reg[ITER]; end
                default: begin cos_out <= y_reg[ITER]; sin_out <= -x_reg[ITER]; end
            endcase
        end
    end

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_top
// UV sphere vertex generator: grid point in, position, normal and texture
// coordinates out.
// ----------------------------------------------------------------------------
// One vertex per clock is accepted and delivered while the output is taken;
// the pipeline holds the phase dividers (35 stages, one quotient bit each),
// the CORDIC (one stage per iteration plus a quadrant fold) and three product
// stages. The whole pipeline advances together and halts while the output
// holds a transfer that is not taken, so a stall loses nothing. An index
// beyond its count (or a count of zero) raises index_error with all other
// fields zero; counts above MAX_SEGMENTS are clipped. Count writes take
// effect on the next accepted item, radius writes on the next item to leave
// the dividers; write only when the pipeline is empty.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
    parameter int MAX_SEGMENTS     = uvsph_pkg::MAX_SEGMENTS_DEF,
    parameter int ANGLE_ITERATIONS = uvsph_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [uvsph_pkg::IDX_W-1:0]     cfg_index,
    input  logic [uvsph_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // stack_index [10:0], sector_index [21:11], zero fill [23:22]
    input  logic [23:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, pos_z (17 each), nrm_x, nrm_y, nrm_z (16 each),
    // tex_u, tex_v (17 each), index_error (1), zero fill to 136 bits
    output logic [135:0]                    m_tdata
);

    localparam int CNT_W = uvsph_pkg::CNT_W;
    localparam int CW    = uvsph_pkg::CW;
    localparam int NUM_W = 35;              // index << 24 plus rounding
    localparam int DLAT  = NUM_W;
    localparam int CLAT  = ANGLE_ITERATIONS + 1;
    localparam int LAT   = DLAT + CLAT + 3;

    // ---- configuration registers ----
    logic [CNT_W-1:0]           sector_count_reg, stack_count_reg;
    logic [uvsph_pkg::RAD_W-1:0] radius_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_count_reg <= 11'd36;
            stack_count_reg  <= 11'd18;
            radius_reg       <= 16'd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                uvsph_pkg::REG_SECTOR_COUNT: sector_count_reg <= cfg_data[CNT_W-1:0];
                uvsph_pkg::REG_STACK_COUNT:  stack_count_reg  <= cfg_data[CNT_W-1:0];
                uvsph_pkg::REG_RADIUS:       radius_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- pipeline control: all stages advance together ----
    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ---- stage 0: effective counts, range check, dividend setup ----
    logic [CNT_W-1:0] stack_idx, sector_idx, cs, ct;
    logic             err_in;
    assign stack_idx  = s_tdata[10:0];
    assign sector_idx = s_tdata[21:11];
    assign cs = (32'(sector_count_reg) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : sector_count_reg;
    assign ct = (32'(stack_count_reg)  > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : stack_count_reg;
    assign err_in = (cs == '0) || (ct == '0) || (sector_idx > cs) || (stack_idx > ct);

    // zero counts replaced by one to keep the divider defined; the result is
    // masked by the error flag anyway
    logic [CNT_W-1:0] cs_d, ct_d;
    assign cs_d = (cs == '0) ? CNT_W'(1) : cs;
    assign ct_d = (ct == '0) ? CNT_W'(1) : ct;

    logic [NUM_W-1:0] n_ps, n_vt, n_u, n_v;
    assign n_ps = (NUM_W'(sector_idx) << 24) + NUM_W'(cs_d >> 1);
    assign n_vt = (NUM_W'(stack_idx)  << 23) + NUM_W'(ct_d >> 1);
    assign n_u  = (NUM_W'(sector_idx) << 16) + NUM_W'(cs_d >> 1);
    assign n_v  = (NUM_W'(stack_idx)  << 16) + NUM_W'(ct_d >> 1);

    logic [NUM_W-1:0] q_ps, q_vt, q_u, q_v;
    logic [0:0]       err_d, unused_a, unused_b, unused_c;

    uvsph_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_ps (
        .aclk(aclk), .adv(adv), .num(n_ps), .den(cs_d), .side_in(err_in),
        .quo(q_ps), .side_out(err_d));
    uvsph_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_vt (
        .aclk(aclk), .adv(adv), .num(n_vt), .den(ct_d), .side_in(1'b0),
        .quo(q_vt), .side_out(unused_a));
    uvsph_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_u (
        .aclk(aclk), .adv(adv), .num(n_u), .den(cs_d), .side_in(1'b0),
        .quo(q_u), .side_out(unused_b));
    uvsph_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W), .SIDE_W(1)) u_div_v (
        .aclk(aclk), .adv(adv), .num(n_v), .den(ct_d), .side_in(1'b0),
        .quo(q_v), .side_out(unused_c));

    // ---- angles to sine and cosine ----
    logic [23:0] ps_phase, pt_phase;
    assign ps_phase = q_ps[23:0];
    assign pt_phase = 24'd4194304 - q_vt[23:0];

    logic signed [CW-1:0] cos_t, sin_t, cos_s, sin_s;
    uvsph_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_t (
        .aclk(aclk), .adv(adv), .phase(pt_phase), .cos_out(cos_t), .sin_out(sin_t));
    uvsph_cordic #(.ITER(ANGLE_ITERATIONS)) u_cordic_s (
        .aclk(aclk), .adv(adv), .phase(ps_phase), .cos_out(cos_s), .sin_out(sin_s));

    // delay texture coordinates and the error flag alongside the CORDIC
    logic [16:0] tu_reg [CLAT+3];
    logic [16:0] tv_reg [CLAT+3];
    logic        er_reg [CLAT+3];
    logic [15:0] rad_reg [CLAT+1];

    always_comb begin
        tu_reg[0]  = q_u[16:0];
        tv_reg[0]  = q_v[16:0];
        er_reg[0]  = err_d[0];
        rad_reg[0] = radius_reg;
    end

    for (genvar k = 0; k < CLAT + 2; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (adv) begin
                tu_reg[k+1] <= tu_reg[k];
                tv_reg[k+1] <= tv_reg[k];
                er_reg[k+1] <= er_reg[k];
            end
        end
    end
    for (genvar k = 0; k < CLAT; k++) begin : g_rad
        always_ff @(posedge aclk) begin
            if (adv) rad_reg[k+1] <= rad_reg[k];
        end
    end

    // ---- product stage 1: unit vector in Q2.30 ----
    logic signed [2*CW-1:0] px_full, py_full;
    logic signed [CW-1:0]   ux_reg, uy_reg, uz_reg;
    logic [15:0]            r1_reg;
    assign px_full = cos_t * cos_s + (68'sd1 <<< 29);
    assign py_full = cos_t * sin_s + (68'sd1 <<< 29);

    always_ff @(posedge aclk) begin
        if (adv) begin
            ux_reg <= CW'(px_full >>> 30);
            uy_reg <= CW'(py_full >>> 30);
            uz_reg <= sin_t;
            r1_reg <= rad_reg[CLAT];
        end
    end

    // ---- product stage 2: scale by radius, normal rounding ----
    logic signed [CW+17:0] sx, sy, sz;
    logic signed [CW-1:0]  nx_full, ny_full, nz_full;
    logic signed [CW+17:0] sx_reg, sy_reg, sz_reg;
    logic signed [CW-1:0]  nx_reg, ny_reg, nz_reg;
    assign sx = $signed({1'b0, r1_reg}) * ux_reg + ((CW+18)'(1) <<< 29);
    assign sy = $signed({1'b0, r1_reg}) * uy_reg + ((CW+18)'(1) <<< 29);
    assign sz = $signed({1'b0, r1_reg}) * uz_reg + ((CW+18)'(1) <<< 29);
    assign nx_full = (ux_reg + CW'(32768)) >>> 16;
    assign ny_full = (uy_reg + CW'(32768)) >>> 16;
    assign nz_full = (uz_reg + CW'(32768)) >>> 16;

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx_reg <= sx >>> 30;  sy_reg <= sy >>> 30;  sz_reg <= sz >>> 30;
            nx_reg <= nx_full;    ny_reg <= ny_full;    nz_reg <= nz_full;
        end
    end

    // ---- output stage: clamp, mask on error, pack ----
    function automatic logic [16:0] clamp_pos(input logic signed [CW+17:0] v);
        if (v > 65535)       return 17'sd65535;
        else if (v < -65535) return -17'sd65535;
        else                 return v[16:0];
    endfunction
    function automatic logic [15:0] clamp_nrm(input logic signed [CW-1:0] v);
        if (v > 16384)       return 16'sd16384;
        else if (v < -16384) return -16'sd16384;
        else                 return v[15:0];
    endfunction

    logic [135:0] out_reg;
    logic         er_o;
    assign er_o = er_reg[CLAT+2];

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (er_o) begin
                out_reg <= {2'd0, 1'b1, 133'd0};
            end else begin
                out_reg <= {2'd0, 1'b0, tv_reg[CLAT+2], tu_reg[CLAT+2],
                            clamp_nrm(nz_reg), clamp_nrm(ny_reg), clamp_nrm(nx_reg),
                            clamp_pos(sz_reg), clamp_pos(sy_reg), clamp_pos(sx_reg)};
            end
        end
    end
    assign m_tdata = out_reg;

    // ---- assertions ----
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_ready_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[133] |-> m_tdata[132:0] == '0)
        else $error("error result carries data");
    a_cnt_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted transfer not entered");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UV sphere vertex generator: directed grid
// points, then random points over a set of register settings, checked against a
// fixed-point sine/cosine predictor, under bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int LATENCY   = 35 + uvsph_pkg::ANGLE_ITERATIONS_DEF + 4;
    localparam int MAX_CYCLE = 400000;

    // register index with nothing behind it
    localparam logic [uvsph_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic               err;
        logic        [16:0] tv;
        logic        [16:0] tu;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
        logic signed [16:0] pz;
        logic signed [16:0] py;
        logic signed [16:0] px;
    } vertex_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [uvsph_pkg::IDX_W-1:0] cfg_index = '0;
    logic [uvsph_pkg::CFG_W-1:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [135:0] m_tdata;

    // predictor copy of the registers
    longint unsigned sectors_cfg = 36, stacks_cfg = 18, radius_cfg = 256;

    vertex_t expected_vertices[$];
    int      fault_count = 0;
    int      vertex_count = 0;
    int      error_vertex_count = 0;
    longint  cycle = 0;
    bit      hold_off = 1'b0;   // long receiver stall request

    always #5 aclk = ~aclk;

    uv_sphere_vertex_generator_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // rotation CORDIC on a 2^-24 turn phase; returns cosine and sine in Q2.30
    task automatic rotate_phase(input longint unsigned phase, output longint c,
                                output longint s);
        longint unsigned p;
        int      quad;
        longint  x, y, z, dx, dy;
        p    = phase & 64'hFFFFFF;
        quad = int'(((p + 64'd2097152) >> 22) & 3);
        z    = longint'((p + 64'd2097152) & 64'h3FFFFF) - 2097152;
        x    = 652032874;
        y    = 0;
        for (int i = 0; i < uvsph_pkg::ANGLE_ITERATIONS_DEF; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(uvsph_pkg::atan_lookup(i));
            end else begin
                x += dx; y -= dy; z += longint'(uvsph_pkg::atan_lookup(i));
            end
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_vertex(input int stack, input int sector, output vertex_t v);
        longint unsigned cs, ct, ps, vt, pt;
        longint ct_c, ct_s, cs_c, cs_s;
        longint u[3];
        v  = '0;
        cs = (sectors_cfg > 1024) ? 1024 : sectors_cfg;
        ct = (stacks_cfg > 1024) ? 1024 : stacks_cfg;
        if (cs == 0 || ct == 0 || sector > cs || stack > ct) begin
            v.err = 1'b1;
            return;
        end
        ps = ((longint'(sector) << 24) + cs / 2) / cs;
        vt = ((longint'(stack) << 23) + ct / 2) / ct;
        pt = (64'd4194304 - vt) & 64'hFFFFFF;
        rotate_phase(pt, ct_c, ct_s);
        rotate_phase(ps, cs_c, cs_s);
        u[0] = fshift(ct_c * cs_c + (64'sd1 <<< 29), 30);
        u[1] = fshift(ct_c * cs_s + (64'sd1 <<< 29), 30);
        u[2] = ct_s;
        v.px = 17'(clip(fshift(longint'(radius_cfg) * u[0] + (64'sd1 <<< 29), 30), 65535));
        v.py = 17'(clip(fshift(longint'(radius_cfg) * u[1] + (64'sd1 <<< 29), 30), 65535));
        v.pz = 17'(clip(fshift(longint'(radius_cfg) * u[2] + (64'sd1 <<< 29), 30), 65535));
        v.nx = 16'(clip(fshift(u[0] + (64'sd1 <<< 15), 16), 16384));
        v.ny = 16'(clip(fshift(u[1] + (64'sd1 <<< 15), 16), 16384));
        v.nz = 16'(clip(fshift(u[2] + (64'sd1 <<< 15), 16), 16384));
        v.tu = 17'(((longint'(sector) << 16) + cs / 2) / cs);
        v.tv = 17'(((longint'(stack) << 16) + ct / 2) / ct);
    endtask

    task automatic report_fault(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        fault_count++;
    endtask

    // write one register; only called with the pipeline drained
    task automatic write_reg(input logic [uvsph_pkg::IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= uvsph_pkg::CFG_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            uvsph_pkg::REG_SECTOR_COUNT: sectors_cfg = value & 11'h7FF;
            uvsph_pkg::REG_STACK_COUNT:  stacks_cfg  = value & 11'h7FF;
            uvsph_pkg::REG_RADIUS:       radius_cfg  = value & 16'hFFFF;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // offer one grid point and hold it until the transfer; queue the vertex
    // (or the pinned one where a directed row gives it)
    task automatic send_point(input int stack, input int sector,
                              input bit pinned, input vertex_t pin);
        vertex_t v;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, 11'(sector), 11'(stack)};
        do @(posedge aclk); while (!s_tready);
        if (pinned) v = pin;
        else predict_vertex(stack, sector, v);
        expected_vertices = {expected_vertices, v};
    endtask

    task automatic go_quiet();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        go_quiet();
        while (expected_vertices.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // receiver: own stall pattern, with a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            case (cycle[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // check each delivered vertex against the oldest expectation
    always @(posedge aclk) begin
        vertex_t got, want;
        cycle <= cycle + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = vertex_t'(m_tdata[133:0]);
            if (expected_vertices.size() == 0) begin
                report_fault("unexpected vertex", 0, 0);
            end else begin
                want = expected_vertices.pop_front();
                vertex_count++;
                if (want.err) error_vertex_count++;
                if (got.px != want.px) report_fault("pos_x", got.px, want.px);
                if (got.py != want.py) report_fault("pos_y", got.py, want.py);
                if (got.pz != want.pz) report_fault("pos_z", got.pz, want.pz);
                if (got.nx != want.nx) report_fault("nrm_x", got.nx, want.nx);
                if (got.ny != want.ny) report_fault("nrm_y", got.ny, want.ny);
                if (got.nz != want.nz) report_fault("nrm_z", got.nz, want.nz);
                if (got.tu != want.tu) report_fault("tex_u", got.tu, want.tu);
                if (got.tv != want.tv) report_fault("tex_v", got.tv, want.tv);
                if (got.err != want.err) report_fault("index_error", got.err, want.err);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycle > MAX_CYCLE) begin
            $display("uv_sphere_vertex_generator_top test failed");
            $finish;
        end
    end

    // directed rows: stack, sector, pinned flag and pinned vertex
    typedef struct {
        int      stack;
        int      sector;
        bit      pinned;
        vertex_t pin;
    } point_row_t;

    localparam vertex_t ERR_VTX = '{err: 1'b1, default: '0};

    point_row_t directed_points[] = '{
        '{0, 0, 1'b0, '0},        // top pole
        '{18, 0, 1'b0, '0},       // bottom pole
        '{9, 0, 1'b0, '0},        // equator, angle zero
        '{9, 9, 1'b0, '0},        // equator, quarter turn
        '{9, 18, 1'b0, '0},       // equator, half turn
        '{9, 27, 1'b0, '0},
        '{9, 36, 1'b0, '0},       // sector equal to count
        '{4, 5, 1'b0, '0},
        '{13, 31, 1'b0, '0},
        '{19, 0, 1'b1, ERR_VTX},  // stack beyond count
        '{0, 37, 1'b1, ERR_VTX},  // sector beyond count
        '{2047, 2047, 1'b1, ERR_VTX},
        '{1024, 1024, 1'b1, ERR_VTX}
    };

    task automatic random_points(input int n, input int smax, input int tmax);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && n > 0; k++, n--) begin
                // mostly in range, sometimes anywhere in the 11-bit field
                if ($urandom_range(0, 9) == 0)
                    send_point($urandom_range(0, 2047), $urandom_range(0, 2047), 0, '0);
                else
                    send_point($urandom_range(0, tmax), $urandom_range(0, smax), 0, '0);
            end
            if ($urandom_range(0, 2) != 0) begin
                go_quiet();
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    int settings[][3] = '{
        '{1, 1, 1},
        '{1024, 1024, 65535},
        '{2047, 2047, 40000},     // counts above the segment limit
        '{0, 18, 256},            // zero sector count
        '{36, 0, 256},            // zero stack count
        '{7, 5, 0},               // zero radius
        '{100, 50, 1000},
        '{3, 1024, 65535}
    };

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed points at reset configuration
        foreach (directed_points[i])
            send_point(directed_points[i].stack, directed_points[i].sector,
                       directed_points[i].pinned, directed_points[i].pin);
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_off = 1'b1;
        fork
            random_points(120, 36, 18);
            begin
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
        drain();

        foreach (settings[i]) begin
            write_reg(uvsph_pkg::REG_SECTOR_COUNT, settings[i][0]);
            write_reg(uvsph_pkg::REG_STACK_COUNT, settings[i][1]);
            write_reg(uvsph_pkg::REG_RADIUS, settings[i][2]);
            write_reg(REG_UNMAPPED, $urandom_range(0, 65535));   // ignored
            send_point(0, 0, 0, '0);
            send_point(settings[i][1], settings[i][0], 0, '0);
            random_points(50,
                          (settings[i][0] > 1024) ? 1024 : settings[i][0] + 1,
                          (settings[i][1] > 1024) ? 1024 : settings[i][1] + 1);
            drain();
        end

        $display("Covered %0d vertices (%0d index errors) over %0d register settings",
                 vertex_count, error_vertex_count, settings.size() + 1);
        if (fault_count == 0 && expected_vertices.size() == 0) begin
            $display("uv_sphere_vertex_generator_top test passed");
        end else begin
            $display("uv_sphere_vertex_generator_top test failed");
        end
        $finish;
    end

endmodule
